// File: rtl/core/ple_pkg.sv
// Shared types and codes of the positional list engine.
package ple_pkg;

  // Request modes.
  localparam logic [2:0] MODE_INS_FRONT = 3'd0;
  localparam logic [2:0] MODE_INS_BACK  = 3'd1;
  localparam logic [2:0] MODE_INS_AT    = 3'd2;
  localparam logic [2:0] MODE_DEL_FRONT = 3'd3;
  localparam logic [2:0] MODE_DEL_BACK  = 3'd4;
  localparam logic [2:0] MODE_DEL_AT    = 3'd5;
  localparam logic [2:0] MODE_WALK      = 3'd6;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // Operation a request resolves to once the list state is known.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ERR,
    OP_INS_FRONT,
    OP_INS_BACK,
    OP_INS_POS,
    OP_DEL_HEAD,
    OP_DEL_POS,
    OP_WALK
  } op_e;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_START,
    CMD_ERR,
    CMD_FOLLOW,
    CMD_FOLLOW_DONE,
    CMD_TAKE,
    CMD_LINK,
    CMD_DEL_HEAD,
    CMD_DEL_NODE,
    CMD_DEL_FREE,
    CMD_WALK_EMIT
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FOLLOW,
    S_TAKE,
    S_LINK,
    S_DEL_HEAD,
    S_DEL_NODE,
    S_DEL_FREE,
    S_WALK
  } state_e;

  typedef struct packed {
    op_e  op_now;
    op_e  op_q;
    logic steps_zero;
    logic walk_last;
    logic can_emit;
  } dp_status_t;

endpackage

// File: rtl/core/positional_list_engine_core.sv
// Top level of the positional list engine: bounded singly linked list of signed words.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+----------------------------------------
//   in      | input     | in_valid_i / in_ready_o | mode_i, position_i, value_i
//   out     | output    | out_valid_o / out_ready_i | status_o, item_value_o,
//           |           |                        |   item_position_o, last_item_o
//
// One request is worked at a time. Positional inserts and deletes, and a delete at the back
// of a list with more than one item, follow links one node per cycle to the node before
// the target. A walk emits one word per cycle while the output register can take it.
// After reset the free chain is read from per-entry valid bits, so no clearing pass runs.
// A stalled output holds the sequencer at its next result until the output register frees.
module positional_list_engine_core #(
  parameter int CAPACITY = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         mode_i,
  input  logic [5:0]         position_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] item_value_o,
  output logic [5:0]         item_position_o,
  output logic               last_item_o
);
  import ple_pkg::*;

  cmd_e       cmd;
  dp_status_t dp_status;

  ple_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  ple_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (dp_status),
    .mode_i          (mode_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_status_o    (status_o),
    .item_value_o    (item_value_o),
    .item_position_o (item_position_o),
    .last_item_o     (last_item_o)
  );

endmodule

// File: rtl/core/ple_datapath.sv
// Datapath of the positional list engine: list registers, node and link memories, result register.
module ple_datapath #(
  parameter int CAPACITY = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ple_pkg::cmd_e      cmd_i,
  output ple_pkg::dp_status_t status_o,
  input  logic [2:0]         mode_i,
  input  logic [5:0]         position_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         out_status_o,
  output logic signed [31:0] item_value_o,
  output logic [5:0]         item_position_o,
  output logic               last_item_o
);
  import ple_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = ((CW > 6) ? CW : 6) + 1;

  // Latched request.
  logic [2:0]         mode_q;
  logic [5:0]         pos_q;
  logic signed [31:0] val_q;

  // List state and walk registers.
  logic [IW-1:0] head_q, head_d, tail_q, tail_d, free_q, free_d;
  logic [IW-1:0] cursor_q, cursor_d, prev_q, prev_d, save_q, save_d;
  logic [CW-1:0] count_q, count_d, steps_q, steps_d, k_q, k_d;
  op_e           op_q, op_d;

  // Memories.
  logic signed [31:0] vmem_q [CAPACITY];
  logic [IW-1:0]      lmem_q [CAPACITY];
  logic [CAPACITY-1:0] lvalid_q;
  logic [IW-1:0]      raddr, raddr_q;
  logic signed [31:0] val_rd_q;
  logic [IW-1:0]      lmem_rd_q, link_rd;
  logic               lrv_q;
  logic               lwe, vwe;
  logic [IW-1:0]      lwaddr, lwdata;

  // Result register.
  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic signed [31:0] out_value_q;
  logic [5:0]         out_pos_q;
  logic               out_last_q;
  logic               emit, can_emit;
  logic [1:0]         emit_status;
  logic signed [31:0] emit_value;
  logic [5:0]         emit_pos;
  logic               emit_last;

  // Decode of the latched request against the list state.
  op_e           op_now;
  logic [1:0]    err_now;
  logic [KW-1:0] pe, ce, p_now;
  logic [CW-1:0] steps_now;

  // A link entry never written reads as its free-chain reset value.
  assign link_rd = lrv_q ? lmem_rd_q :
                   ((raddr_q == IW'(CAPACITY - 1)) ? '0 : raddr_q + IW'(1));

  assign can_emit = !out_valid_q || out_ready_i;

  always_comb begin
    pe      = KW'(pos_q);
    ce      = KW'(count_q);
    op_now  = OP_NONE;
    err_now = ST_OK;
    p_now   = '0;
    unique case (mode_q)
      MODE_INS_FRONT: op_now = OP_INS_FRONT;
      MODE_INS_BACK:  op_now = OP_INS_BACK;
      MODE_INS_AT: begin
        if (pos_q == '0 || pe > ce + KW'(1)) begin
          op_now  = OP_ERR;
          err_now = ST_BADPOS;
        end else if (pos_q == 6'd1) begin
          op_now = OP_INS_FRONT;
        end else if (pe == ce + KW'(1)) begin
          op_now = OP_INS_BACK;
        end else begin
          op_now = OP_INS_POS;
          p_now  = pe;
        end
      end
      MODE_DEL_FRONT: begin
        if (count_q == '0) begin
          op_now  = OP_ERR;
          err_now = ST_EMPTY;
        end else begin
          op_now = OP_DEL_HEAD;
        end
      end
      MODE_DEL_BACK: begin
        if (count_q == '0) begin
          op_now  = OP_ERR;
          err_now = ST_EMPTY;
        end else if (count_q == CW'(1)) begin
          op_now = OP_DEL_HEAD;
        end else begin
          op_now = OP_DEL_POS;
          p_now  = ce;
        end
      end
      MODE_DEL_AT: begin
        if (count_q == '0) begin
          op_now  = OP_ERR;
          err_now = ST_EMPTY;
        end else if (pos_q == '0 || pe > ce) begin
          op_now  = OP_ERR;
          err_now = ST_BADPOS;
        end else if (pos_q == 6'd1) begin
          op_now = OP_DEL_HEAD;
        end else begin
          op_now = OP_DEL_POS;
          p_now  = pe;
        end
      end
      MODE_WALK: begin
        if (count_q == '0) begin
          op_now  = OP_ERR;
          err_now = ST_EMPTY;
        end else begin
          op_now = OP_WALK;
        end
      end
      default: op_now = OP_NONE;
    endcase
    if ((op_now == OP_INS_FRONT || op_now == OP_INS_BACK || op_now == OP_INS_POS) &&
        count_q == CW'(CAPACITY)) begin
      op_now  = OP_ERR;
      err_now = ST_FULL;
    end
    // The walk to the node before the target takes position minus two steps.
    steps_now = CW'(p_now - KW'(2));
  end

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    free_d      = free_q;
    cursor_d    = cursor_q;
    prev_d      = prev_q;
    save_d      = save_q;
    count_d     = count_q;
    steps_d     = steps_q;
    k_d         = k_q;
    op_d        = op_q;
    raddr       = cursor_q;
    lwe         = 1'b0;
    lwaddr      = cursor_q;
    lwdata      = free_q;
    vwe         = 1'b0;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_value  = '0;
    emit_pos    = '0;
    emit_last   = 1'b1;
    unique case (cmd_i)
      CMD_NONE, CMD_LATCH: ;
      CMD_START: begin
        op_d    = op_now;
        steps_d = steps_now;
        k_d     = CW'(1);
        if (op_now == OP_INS_FRONT || op_now == OP_INS_BACK) begin
          cursor_d = free_q;
          raddr    = free_q;
        end else begin
          cursor_d = head_q;
          raddr    = head_q;
        end
      end
      CMD_ERR: begin
        emit        = 1'b1;
        emit_status = err_now;
      end
      CMD_FOLLOW: begin
        cursor_d = link_rd;
        raddr    = link_rd;
        steps_d  = steps_q - CW'(1);
      end
      CMD_FOLLOW_DONE: begin
        prev_d = cursor_q;
        if (op_q == OP_INS_POS) begin
          save_d   = link_rd;
          cursor_d = free_q;
          raddr    = free_q;
        end else begin
          cursor_d = link_rd;
          raddr    = link_rd;
        end
      end
      CMD_TAKE: begin
        // The cursor holds the node taken from the free list.
        free_d  = link_rd;
        vwe     = 1'b1;
        count_d = count_q + CW'(1);
        case (op_q)
          OP_INS_FRONT: begin
            lwe    = 1'b1;
            lwaddr = cursor_q;
            lwdata = head_q;
            head_d = cursor_q;
            if (count_q == '0) tail_d = cursor_q;
          end
          OP_INS_BACK: begin
            if (count_q == '0) begin
              head_d = cursor_q;
            end else begin
              lwe    = 1'b1;
              lwaddr = tail_q;
              lwdata = cursor_q;
            end
            tail_d = cursor_q;
          end
          default: begin
            lwe    = 1'b1;
            lwaddr = cursor_q;
            lwdata = save_q;
          end
        endcase
        emit = (op_q != OP_INS_POS);
      end
      CMD_LINK: begin
        lwe    = 1'b1;
        lwaddr = prev_q;
        lwdata = cursor_q;
        emit   = 1'b1;
      end
      CMD_DEL_HEAD: begin
        head_d     = link_rd;
        lwe        = 1'b1;
        lwaddr     = cursor_q;
        lwdata     = free_q;
        free_d     = cursor_q;
        count_d    = count_q - CW'(1);
        if (count_q == CW'(1)) begin
          head_d = '0;
          tail_d = '0;
        end
        emit       = 1'b1;
        emit_value = val_rd_q;
      end
      CMD_DEL_NODE: begin
        lwe    = 1'b1;
        lwaddr = prev_q;
        lwdata = link_rd;
        if (cursor_q == tail_q) tail_d = prev_q;
      end
      CMD_DEL_FREE: begin
        lwe        = 1'b1;
        lwaddr     = cursor_q;
        lwdata     = free_q;
        free_d     = cursor_q;
        count_d    = count_q - CW'(1);
        if (count_q == CW'(1)) begin
          head_d = '0;
          tail_d = '0;
        end
        emit       = 1'b1;
        emit_value = val_rd_q;
      end
      CMD_WALK_EMIT: begin
        emit       = 1'b1;
        emit_value = val_rd_q;
        emit_pos   = 6'(k_q);
        emit_last  = (k_q == count_q);
        cursor_d   = link_rd;
        raddr      = link_rd;
        k_d        = k_q + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      free_q      <= '0;
      count_q     <= '0;
      op_q        <= OP_NONE;
      lvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      free_q  <= free_d;
      count_q <= count_d;
      op_q    <= op_d;
      if (lwe) lvalid_q[lwaddr] <= 1'b1;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cursor_q <= cursor_d;
    prev_q   <= prev_d;
    save_q   <= save_d;
    steps_q  <= steps_d;
    k_q      <= k_d;
    if (cmd_i == CMD_LATCH) begin
      mode_q <= mode_i;
      pos_q  <= position_i;
      val_q  <= value_i;
    end
    if (emit) begin
      out_status_q <= emit_status;
      out_value_q  <= emit_value;
      out_pos_q    <= emit_pos;
      out_last_q   <= emit_last;
    end
  end

  // Node and link memories, one write and one registered read each per cycle.
  always_ff @(posedge clk_i) begin
    if (vwe) vmem_q[cursor_q] <= val_q;
    if (lwe) lmem_q[lwaddr] <= lwdata;
    val_rd_q  <= vmem_q[raddr];
    lmem_rd_q <= lmem_q[raddr];
    lrv_q     <= lvalid_q[raddr];
    raddr_q   <= raddr;
  end

  assign status_o.op_now     = op_now;
  assign status_o.op_q       = op_q;
  assign status_o.steps_zero = (steps_q == '0);
  assign status_o.walk_last  = (k_q == count_q);
  assign status_o.can_emit   = can_emit;

  assign out_valid_o     = out_valid_q;
  assign out_status_o    = out_status_q;
  assign item_value_o    = out_value_q;
  assign item_position_o = out_pos_q;
  assign last_item_o     = out_last_q;

endmodule

// File: rtl/core/ple_ctrl.sv
// Controller state machine of the positional list engine.
module ple_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ple_pkg::dp_status_t status_i,
  output ple_pkg::cmd_e       cmd_o
);
  import ple_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_DECODE;
      S_DECODE: begin
        case (status_i.op_now)
          OP_NONE: state_d = S_IDLE;
          OP_ERR: if (status_i.can_emit) state_d = S_IDLE;
          OP_INS_FRONT, OP_INS_BACK: state_d = S_TAKE;
          OP_INS_POS, OP_DEL_POS: state_d = S_FOLLOW;
          OP_DEL_HEAD: state_d = S_DEL_HEAD;
          default: state_d = S_WALK;
        endcase
      end
      S_FOLLOW: begin
        if (status_i.steps_zero) begin
          state_d = (status_i.op_q == OP_INS_POS) ? S_TAKE : S_DEL_NODE;
        end
      end
      S_TAKE: begin
        if (status_i.op_q == OP_INS_POS) begin
          state_d = S_LINK;
        end else if (status_i.can_emit) begin
          state_d = S_IDLE;
        end
      end
      S_LINK:     if (status_i.can_emit) state_d = S_IDLE;
      S_DEL_HEAD: if (status_i.can_emit) state_d = S_IDLE;
      S_DEL_NODE: state_d = S_DEL_FREE;
      S_DEL_FREE: if (status_i.can_emit) state_d = S_IDLE;
      S_WALK:     if (status_i.can_emit && status_i.walk_last) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = CMD_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o = CMD_LATCH;
      end
      S_DECODE: begin
        case (status_i.op_now)
          OP_NONE: cmd_o = CMD_NONE;
          OP_ERR:  cmd_o = status_i.can_emit ? CMD_ERR : CMD_NONE;
          default: cmd_o = CMD_START;
        endcase
      end
      S_FOLLOW: cmd_o = status_i.steps_zero ? CMD_FOLLOW_DONE : CMD_FOLLOW;
      S_TAKE: begin
        if (status_i.op_q == OP_INS_POS || status_i.can_emit) cmd_o = CMD_TAKE;
      end
      S_LINK:     if (status_i.can_emit) cmd_o = CMD_LINK;
      S_DEL_HEAD: if (status_i.can_emit) cmd_o = CMD_DEL_HEAD;
      S_DEL_NODE: cmd_o = CMD_DEL_NODE;
      S_DEL_FREE: if (status_i.can_emit) cmd_o = CMD_DEL_FREE;
      S_WALK:     if (status_i.can_emit) cmd_o = CMD_WALK_EMIT;
      default:    cmd_o = CMD_NONE;
    endcase
  end

endmodule

// File: tb/positional_list_engine_core_test.sv
// Testbench for positional_list_engine_core: list predictor, scoreboard and random traffic.
module positional_list_engine_core_test;
  import ple_pkg::*;

  localparam int LIST_DEPTH = 32;
  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 420;
  localparam int LONG_HOLD = 300;
  localparam int TIMEOUT_CYCLES = 900000;

  // Mirror of the list: word and link memories, free chain and the head, tail and count.
  class list_scoreboard #(int DEPTH = 32);
    typedef struct {
      logic [1:0]         status;
      logic signed [31:0] value;
      logic [5:0]         position;
      logic               last;
    } result_t;

    logic signed [31:0] word_mem[DEPTH];
    logic [4:0]         next_mem[DEPTH];
    logic [4:0]         head;
    logic [4:0]         tail;
    logic [4:0]         free_top;
    int                 count;
    result_t            pending[$];
    int                 errors;
    int                 requests;
    int                 words;
    int                 walks;
    int                 full_refusals;
    int                 full_hits;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        word_mem[i] = '0;
        next_mem[i] = 5'((i + 1) % DEPTH);
      end
      head = '0;
      tail = '0;
      free_top = '0;
      count = 0;
    endfunction

    function void push_word(logic [1:0] st, logic signed [31:0] val, int pos, logic last);
      result_t r;
      r.status = st;
      r.value = val;
      r.position = 6'(pos);
      r.last = last;
      pending.push_back(r);
    endfunction

    function logic [4:0] node_at(int pos);
      logic [4:0] n;
      n = head;
      for (int i = 1; i < pos; i++) n = next_mem[n];
      return n;
    endfunction

    function logic [4:0] grab(logic signed [31:0] val);
      logic [4:0] n;
      n = free_top;
      free_top = next_mem[n];
      word_mem[n] = val;
      return n;
    endfunction

    // Records an accepted request and queues the result words it must produce.
    function void note(logic [2:0] mode, logic [5:0] position, logic signed [31:0] val);
      logic [2:0] op;
      logic [4:0] node;
      logic [4:0] prev;
      int         at;
      op = mode;
      at = position;
      if (op > MODE_WALK) return;
      requests++;
      if (op == MODE_INS_AT) begin
        if (at == 0 || at > count + 1) begin
          push_word(ST_BADPOS, 0, 0, 1'b1);
          return;
        end
        if (at == 1) op = MODE_INS_FRONT;
        else if (at == count + 1) op = MODE_INS_BACK;
      end
      if (op <= MODE_INS_AT && count >= DEPTH) begin
        full_refusals++;
        push_word(ST_FULL, 0, 0, 1'b1);
        return;
      end
      case (op)
        MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT: begin
          if (op == MODE_INS_AT) prev = node_at(at - 1);
          node = grab(val);
          if (op == MODE_INS_FRONT) begin
            next_mem[node] = head;
            if (count == 0) tail = node;
            head = node;
          end else if (op == MODE_INS_BACK) begin
            if (count == 0) head = node;
            else next_mem[tail] = node;
            tail = node;
          end else begin
            next_mem[node] = next_mem[prev];
            next_mem[prev] = node;
          end
          count++;
          if (count == DEPTH) full_hits++;
          push_word(ST_OK, 0, 0, 1'b1);
        end
        MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_AT: begin
          // An empty list wins over a bad position.
          if (count == 0) begin
            push_word(ST_EMPTY, 0, 0, 1'b1);
            return;
          end
          if (op == MODE_DEL_FRONT) at = 1;
          else if (op == MODE_DEL_BACK) at = count;
          else if (at == 0 || at > count) begin
            push_word(ST_BADPOS, 0, 0, 1'b1);
            return;
          end
          if (at == 1) begin
            node = head;
            head = next_mem[node];
          end else begin
            prev = node_at(at - 1);
            node = next_mem[prev];
            next_mem[prev] = next_mem[node];
            if (node == tail) tail = prev;
          end
          push_word(ST_OK, word_mem[node], 0, 1'b1);
          next_mem[node] = free_top;
          free_top = node;
          count--;
          if (count == 0) begin
            head = '0;
            tail = '0;
          end
        end
        default: begin
          walks++;
          if (count == 0) begin
            push_word(ST_EMPTY, 0, 0, 1'b1);
            return;
          end
          node = head;
          for (int i = 0; i < count; i++) begin
            push_word(ST_OK, word_mem[node], i + 1, (i + 1 == count));
            node = next_mem[node];
          end
        end
      endcase
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task check(logic [1:0] st, logic signed [31:0] val, logic [5:0] pos, logic last);
      result_t want;
      words++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word: status %0d value %0d position %0d last %0b",
                         st, val, pos, last));
        return;
      end
      want = pending.pop_front();
      if (st !== want.status)
        report($sformatf("status %0d, expected %0d", st, want.status));
      if (val !== want.value)
        report($sformatf("item_value %0d, expected %0d", val, want.value));
      if (pos !== want.position)
        report($sformatf("item_position %0d, expected %0d", pos, want.position));
      if (last !== want.last)
        report($sformatf("last_item %0b, expected %0b", last, want.last));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [2:0]         mode_i = MODE_WALK;
  logic [5:0]         position_i = '0;
  logic signed [31:0] value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         status_o;
  logic signed [31:0] item_value_o;
  logic [5:0]         item_position_o;
  logic               last_item_o;

  list_scoreboard #(LIST_DEPTH) sb;
  bit growing = 1'b1;
  bit random_phase = 1'b0;
  int burst_left = 0;

  positional_list_engine_core #(
    .CAPACITY(LIST_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .item_value_o   (item_value_o),
    .item_position_o(item_position_o),
    .last_item_o    (last_item_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check(status_o, item_value_o, item_position_o, last_item_o);
  end

  // Sender works in bursts: zero gaps inside a burst, a random gap between bursts.
  function int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 24);
    return $urandom_range(1, 8);
  endfunction

  task offer(logic [2:0] m, logic [5:0] p, logic signed [31:0] v);
    int gap;
    in_valid_i <= 1'b1;
    mode_i <= m;
    position_i <= p;
    value_i <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note(m, p, v);
    gap = next_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function logic signed [31:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed requests against the current list length, with the mix leaning
  // toward inserts while the list grows and toward deletes while it shrinks.
  task pick_request(output logic [2:0] m, output logic [5:0] p,
                    output logic signed [31:0] v);
    int cnt;
    int roll;
    cnt = sb.count;
    roll = $urandom_range(0, 99);
    if (cnt == LIST_DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
    if (cnt == 0) growing = 1'b1;
    v = pick_value();
    p = 6'($urandom_range(0, 63));
    if (roll < 4) begin
      m = MODE_UNUSED;
    end else if (roll < 11) begin
      m = MODE_WALK;
    end else if (roll < 19) begin
      if ($urandom_range(0, 1) == 0) begin
        m = MODE_INS_AT;
        p = ($urandom_range(0, 2) == 0) ? 6'd0 : 6'($urandom_range(cnt + 2, 63));
      end else begin
        m = MODE_DEL_AT;
        p = ($urandom_range(0, 2) == 0) ? 6'd0 : 6'($urandom_range(cnt + 1, 63));
      end
    end else if ((roll < 80) == growing) begin
      case ($urandom_range(0, 3))
        0:       m = MODE_INS_FRONT;
        1:       m = MODE_INS_BACK;
        default: begin
          m = MODE_INS_AT;
          p = 6'($urandom_range(1, cnt + 1));
        end
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0:       m = MODE_DEL_FRONT;
        1:       m = MODE_DEL_BACK;
        default: begin
          m = MODE_DEL_AT;
          if (cnt > 0) p = 6'($urandom_range(1, cnt));
        end
      endcase
    end
  endtask

  // Receiver alternates stall styles in segments, with one long hold-off early in the
  // random traffic so that the engine backs up into its input.
  initial begin
    int seg;
    int style;
    int tick;
    bit held;
    tick = 0;
    held = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held && random_phase) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      style = $urandom_range(0, 3);
      seg = $urandom_range(5, 60);
      repeat (seg) begin
        case (style)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 2) == 0);
          default: out_ready_i <= (tick % 5) >= 2;
        endcase
        tick++;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * 20);
    $display("[positional_list_engine_core] ERROR");
    $finish;
  end

  initial begin
    logic [2:0]         m;
    logic [5:0]         p;
    logic signed [31:0] v;
    int                 sent;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Requests against an empty list; a delete at a position reports empty first.
    offer(MODE_WALK, 6'd0, '0);
    offer(MODE_DEL_FRONT, 6'd0, '0);
    offer(MODE_DEL_BACK, 6'd0, '0);
    offer(MODE_DEL_AT, 6'd5, '0);
    offer(MODE_INS_AT, 6'd0, 32'sd5);
    offer(MODE_INS_AT, 6'd2, 32'sd6);
    // Position 1 acts as a front insert, position count+1 as a back insert.
    offer(MODE_INS_AT, 6'd1, 32'sh7fff_ffff);
    offer(MODE_INS_BACK, 6'd0, 32'sh8000_0000);
    offer(MODE_INS_AT, 6'd2, 32'sd0);
    offer(MODE_INS_AT, 6'd4, -32'sd1);
    offer(MODE_INS_FRONT, 6'd0, 32'sh5555_aaaa);
    offer(MODE_WALK, 6'd63, '0);
    offer(MODE_DEL_AT, 6'd0, '0);
    offer(MODE_DEL_AT, 6'd6, '0);
    offer(MODE_INS_AT, 6'd63, 32'sd9);
    offer(MODE_DEL_AT, 6'd1, '0);
    offer(MODE_DEL_AT, 6'd2, '0);
    // Deleting the last position must move the tail back one node.
    offer(MODE_DEL_AT, 6'd3, '0);
    offer(MODE_INS_BACK, 6'd0, 32'sh1234_5678);
    offer(MODE_DEL_BACK, 6'd0, '0);
    offer(MODE_WALK, 6'd0, '0);
    offer(MODE_UNUSED, 6'd63, -32'sd1);
    offer(MODE_DEL_FRONT, 6'd0, '0);
    offer(MODE_DEL_BACK, 6'd0, '0);
    offer(MODE_INS_BACK, 6'd0, 32'sd42);
    offer(MODE_WALK, 6'd0, '0);

    random_phase = 1'b1;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick_request(m, p, v);
      offer(m, p, v);
      if (m != MODE_UNUSED) sent++;
    end
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Summary: %0d requests sent, %0d result words checked, %0d of them walks.",
             sb.requests, sb.words, sb.walks);
    $display("Summary: the list reached capacity %0d times and refused %0d inserts as full.",
             sb.full_hits, sb.full_refusals);
    if (sb.errors == 0) begin
      $display("[positional_list_engine_core] OK");
    end else begin
      $display("[positional_list_engine_core] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ple_pkg.sv
rtl/core/ple_datapath.sv
rtl/core/ple_ctrl.sv
rtl/core/positional_list_engine_core.sv
tb/positional_list_engine_core_test.sv
